FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk and skipped while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tbma_pkg.sv
`default_nettype none
package tbma_pkg;

  localparam int MAP_ENTRIES = 4096;
  localparam int PHYS_BLOCKS = 4096;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int PHYS_AW     = $clog2(PHYS_BLOCKS);
  localparam int CLR_DEPTH   = (MAP_ENTRIES > PHYS_BLOCKS) ? MAP_ENTRIES : PHYS_BLOCKS;
  localparam int CLR_W       = $clog2(CLR_DEPTH);
  localparam int QDEPTH      = 2;

  localparam logic [12:0] CNT_MAX = 13'h1FFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_OFFSET   = 2'd0;
  localparam logic [1:0] REG_SIZE     = 2'd1;
  localparam logic [1:0] REG_PHYS_CNT = 2'd2;
  localparam logic [1:0] REG_RESERVED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_MAPPED   = 3'd0;
  localparam logic [2:0] ST_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_NEW      = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [11:0] logical_block;
  } in_item_t;

  typedef struct packed {
    logic [11:0] physical_block;
    logic [2:0]  status;
    logic [12:0] used_count;
  } out_item_t;

  typedef struct packed {
    logic [11:0] partition_offset;
    logic [12:0] partition_size;
    logic [12:0] phys_block_count;
    logic [12:0] reserved_blocks;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic              opcode;
    logic              out_of_range;
    logic [MAP_AW-1:0] idx;
  } q_item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_SCAN_RD,
    BK_SCAN_CHK
  } back_state_t;

endpackage
`default_nettype wire

FILE: hdl/tbma_front.sv
`default_nettype none
module tbma_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbma_pkg::cfg_t    cfg,
  input  wire logic              clearing,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tbma_pkg::in_item_t in_data,
  output logic                   q_valid,
  output tbma_pkg::q_item_t      q_head,
  input  wire logic              q_pop
);
  import tbma_pkg::*;

  q_item_t                     q_mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]   wr_ptr;
  logic [$clog2(QDEPTH)-1:0]   rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;
  logic                        push;
  logic [12:0]                 idx_sum;
  q_item_t                     item;

  // Range check and map index of the incoming request.
  always_comb begin
    idx_sum           = {1'b0, cfg.partition_offset} + {1'b0, in_data.logical_block};
    item.opcode       = in_data.opcode;
    item.out_of_range = ({1'b0, in_data.logical_block} >= cfg.partition_size) ||
                        (32'(idx_sum) >= MAP_ENTRIES);
    item.idx          = idx_sum[MAP_AW-1:0];
  end

  // Hold off transfers while the queue is full or the tables are clearing.
  assign in_stall = clearing || (count == ($clog2(QDEPTH+1))'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (($clog2(QDEPTH+1))'(push)) - (($clog2(QDEPTH+1))'(q_pop));
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tbma_back.sv
`default_nettype none
module tbma_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tbma_pkg::cfg_t     cfg,
  output logic                    clearing,
  input  wire logic               q_valid,
  input  wire tbma_pkg::q_item_t  q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tbma_pkg::out_item_t     out_data
);
  import tbma_pkg::*;
  `include "assert_macros.svh"

  logic [11:0] map_mem  [MAP_ENTRIES];
  logic        used_mem [PHYS_BLOCKS];

  back_state_t       state, state_next;
  logic              cur_op, cur_op_next;
  logic [MAP_AW-1:0] cur_idx, cur_idx_next;
  logic [11:0]       ptr, ptr_next;
  logic [12:0]       tries, tries_next;
  logic [11:0]       scan_ptr, scan_ptr_next;
  logic [12:0]       total, total_next;
  logic [CLR_W-1:0]  clr_cnt, clr_cnt_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic              map_we;
  logic [MAP_AW-1:0] map_addr;
  logic [11:0]       map_wdata;
  logic [11:0]       map_rd;
  logic              used_we;
  logic [PHYS_AW-1:0] used_addr;
  logic              used_wdata;
  logic              used_rd;

  logic [12:0] limit;
  logic [12:0] ptr_inc;
  logic [11:0] ptr_wrap;
  logic        taken;

  assign clearing = (state == BK_CLEAR);
  assign limit    = (32'(cfg.phys_block_count) > PHYS_BLOCKS) ? 13'(PHYS_BLOCKS)
                                                              : cfg.phys_block_count;
  assign ptr_inc  = {1'b0, ptr} + 13'd1;
  assign ptr_wrap = (ptr_inc >= limit) ? 12'd1 : ptr_inc[11:0];
  assign taken    = ({1'b0, ptr} < cfg.reserved_blocks) || used_rd;

  // Table memories with registered reads.
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_addr] <= map_wdata;
    map_rd <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_addr] <= used_wdata;
    used_rd <= used_mem[used_addr];
  end

  // Sequencer: clear pass, lookup, free-block scan and result load.
  always_comb begin
    state_next     = state;
    cur_op_next    = cur_op;
    cur_idx_next   = cur_idx;
    ptr_next       = ptr;
    tries_next     = tries;
    scan_ptr_next  = scan_ptr;
    total_next     = total;
    clr_cnt_next   = clr_cnt;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    q_pop          = 1'b0;
    map_we         = 1'b0;
    map_addr       = cur_idx;
    map_wdata      = ptr;
    used_we        = 1'b0;
    used_addr      = ptr[PHYS_AW-1:0];
    used_wdata     = 1'b1;

    unique case (state)
      BK_CLEAR: begin
        map_we       = 1'b1;
        used_we      = 1'b1;
        map_addr     = clr_cnt[MAP_AW-1:0];
        used_addr    = clr_cnt[PHYS_AW-1:0];
        map_wdata    = '0;
        used_wdata   = 1'b0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        map_addr = q_head.idx;
        if (q_valid && !out_valid) begin
          q_pop        = 1'b1;
          cur_op_next  = q_head.opcode;
          cur_idx_next = q_head.idx;
          if (q_head.out_of_range) begin
            out_valid_next = 1'b1;
            out_data_next  = '{physical_block: 12'd0, status: ST_RANGE, used_count: total};
          end else begin
            state_next = BK_LOOK;
          end
        end
      end
      BK_LOOK: begin
        if (map_rd != 12'd0) begin
          out_valid_next = 1'b1;
          out_data_next  = '{physical_block: map_rd, status: ST_MAPPED, used_count: total};
          state_next     = BK_IDLE;
        end else if (!cur_op) begin
          out_valid_next = 1'b1;
          out_data_next  = '{physical_block: 12'd0, status: ST_UNMAPPED, used_count: total};
          state_next     = BK_IDLE;
        end else if (limit < 13'd2) begin
          out_valid_next = 1'b1;
          out_data_next  = '{physical_block: 12'd0, status: ST_NOSPACE, used_count: total};
          state_next     = BK_IDLE;
        end else begin
          ptr_next   = (scan_ptr == 12'd0 || {1'b0, scan_ptr} >= limit) ? 12'd1 : scan_ptr;
          tries_next = 13'd1;
          state_next = BK_SCAN_RD;
        end
      end
      BK_SCAN_RD: begin
        state_next = BK_SCAN_CHK;
      end
      BK_SCAN_CHK: begin
        if (!taken) begin
          map_we         = 1'b1;
          used_we        = 1'b1;
          scan_ptr_next  = ptr;
          total_next     = (total < CNT_MAX) ? total + 13'd1 : total;
          out_valid_next = 1'b1;
          out_data_next  = '{physical_block: ptr, status: ST_NEW, used_count: total_next};
          state_next     = BK_IDLE;
        end else if (tries + 13'd1 >= limit) begin
          scan_ptr_next  = ptr_wrap;
          out_valid_next = 1'b1;
          out_data_next  = '{physical_block: 12'd0, status: ST_NOSPACE, used_count: total};
          state_next     = BK_IDLE;
        end else begin
          ptr_next   = ptr_wrap;
          tries_next = tries + 13'd1;
          state_next = BK_SCAN_RD;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      scan_ptr  <= 12'd1;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      scan_ptr  <= scan_ptr_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op   <= cur_op_next;
    cur_idx  <= cur_idx_next;
    ptr      <= ptr_next;
    tries    <= tries_next;
    out_data <= out_data_next;
  end

  `ASSERT_CLK(a_scan_ptr_nonzero, scan_ptr != 12'd0, "scan pointer reached zero")
  `ASSERT_CLK(a_pop_when_idle, q_pop |-> (state == BK_IDLE && !out_valid),
              "queue popped outside idle")
  `ASSERT_CLK(a_new_block_nonzero, (out_valid && out_data.status == ST_NEW) |->
              (out_data.physical_block != 12'd0), "allocated block zero")
  `ASSERT_CLK(a_tries_bounded, (state == BK_SCAN_CHK) |-> (tries < limit),
              "scan ran past its candidate count")

endmodule
`default_nettype wire

FILE: hdl/thin_block_map_allocator.sv
`default_nettype none
// Thin-provisioned block map with a bitmap allocator.
// Input channel (in_valid/in_stall/in_data) takes a read or write request for
// a logical block; output channel (out_valid/out_stall/out_data) returns one
// result per request, in order. A transfer happens on a clock edge with valid
// high and stall low. Configuration is written through cfg_write, cfg_index
// and cfg_data, one register per cycle; the user must write it only while
// the block is idle, which the block itself does not enforce. A front stage
// range-checks each request and places it in a two-entry queue; the back
// sequencer does the map lookup and, for a write to an unmapped block, a
// free-block scan of the bitmap, reading and then checking each candidate.
// A scan visits up to limit - 1 candidates, where limit is phys_block_count
// capped at 4096. Only one request is in the back sequencer at a time; the
// next is not taken from the queue until the result has been transferred.
// After reset both tables are cleared, one entry per cycle across all 4096
// entries, and in_stall stays high until the pass is done. While out_stall
// is high the result register holds; the queue can still take requests
// until its two entries are full.
module thin_block_map_allocator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [12:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tbma_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tbma_pkg::out_item_t      out_data
);
  import tbma_pkg::*;

  cfg_t    cfg;
  logic    clearing;
  logic    q_valid;
  q_item_t q_head;
  logic    q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.partition_offset <= '0;
      cfg.partition_size   <= '0;
      cfg.phys_block_count <= 13'd4096;
      cfg.reserved_blocks  <= 13'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET:   cfg.partition_offset <= cfg_data[11:0];
        REG_SIZE:     cfg.partition_size   <= cfg_data;
        REG_PHYS_CNT: cfg.phys_block_count <= cfg_data;
        REG_RESERVED: cfg.reserved_blocks  <= cfg_data;
        default: ;
      endcase
    end
  end

  tbma_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  tbma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
